FILE: design/psbd_pkg.sv
// Shared types and constants for the per-source burst detector.
// No dependencies; every other design file imports this package.
`default_nettype none

package psbd_pkg;

    localparam int MAC_W      = 48;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 16;
    localparam int WIN_W      = 16;
    localparam int CD_W       = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_RST   = 16'd3000;
    localparam logic [CNT_W-1:0] BURST_RST    = 16'd6;
    localparam logic [CD_W-1:0]  COOLDOWN_RST = 20'd15000;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // item commands
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic              command;
        logic [MAC_W-1:0]  transmitter_mac;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic             burst_detected;
        logic [CNT_W-1:0] frame_count;
    } t_out_item;

    typedef struct packed {
        logic [WIN_W-1:0] window_ms;
        logic [CNT_W-1:0] burst_frames;
        logic [CD_W-1:0]  cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic [MAC_W-1:0]  address;
        logic [TIME_W-1:0] window_start;
        logic [CNT_W-1:0]  frame_count;
        logic [TIME_W-1:0] last_fire;
    } t_slot_entry;

    typedef struct packed {
        logic      vld;
        t_out_item item;
    } t_seq_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_WALK_END,
        ST_DECIDE,
        ST_WIN,
        ST_FIRE,
        ST_CLR
    } t_state;

endpackage

`default_nettype wire

FILE: design/psbd_time_alu.sv
// Shared wrap-safe time unit: elapsed = now - base (mod 2^32), compared to a limit.
// Depends on psbd_pkg.
`default_nettype none

module psbd_time_alu (
    input  wire logic [psbd_pkg::TIME_W-1:0] i_now,
    input  wire logic [psbd_pkg::TIME_W-1:0] i_base,
    input  wire logic [psbd_pkg::TIME_W-1:0] i_limit,
    output logic      [psbd_pkg::TIME_W-1:0] o_diff,
    output logic                             o_gt,
    output logic                             o_lt
);
    import psbd_pkg::*;

    assign o_diff = i_now - i_base;
    assign o_gt   = (o_diff > i_limit);
    assign o_lt   = (o_diff < i_limit);

endmodule

`default_nettype wire

FILE: design/psbd_slot_mem.sv
// Tracker table storage: one write port, one registered read port.
// Depends on psbd_pkg for the entry layout.
`default_nettype none

module psbd_slot_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire psbd_pkg::t_slot_entry i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output psbd_pkg::t_slot_entry      o_rdata
);
    import psbd_pkg::*;

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/psbd_seq.sv
// Sequencer: walks the slot table one entry per cycle, then updates the chosen tracker.
// Depends on psbd_pkg, psbd_time_alu and psbd_slot_mem.
`default_nettype none

module psbd_seq #(
    parameter int TRACK_SLOTS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire psbd_pkg::t_in_item i_in_item,
    input  wire psbd_pkg::t_cfg     i_cfg,
    input  wire logic              i_out_free,
    output psbd_pkg::t_seq_res      o_res
);
    import psbd_pkg::*;

    localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TRACK_SLOTS - 1);

    t_state r_state, n_state;

    logic [TRACK_SLOTS-1:0] r_valid;
    logic                   r_eval_vld;
    logic [IW-1:0]          r_walk_idx, r_eval_idx;
    logic [IW-1:0]          r_match_idx, r_free_idx, r_best_idx, r_slot;
    logic                   r_found, r_have_free;
    logic [TIME_W-1:0]      r_best_age;
    logic [MAC_W-1:0]       r_mac;
    logic [TIME_W-1:0]      r_now, r_ws, r_lf;
    logic [CNT_W-1:0]       r_cnt;
    t_slot_entry            r_ent;

    logic              mem_re, mem_we;
    t_slot_entry       mem_rdata, mem_wdata;
    logic [TIME_W-1:0] alu_base, alu_limit, alu_diff;
    logic              alu_gt, alu_lt;

    logic              slot_is_valid, hit, fire;
    logic [IW-1:0]     slot_sel;
    logic [CNT_W-1:0]  cnt_base, cnt_inc;

    psbd_time_alu u_alu (
        .i_now   (r_now),
        .i_base  (alu_base),
        .i_limit (alu_limit),
        .o_diff  (alu_diff),
        .o_gt    (alu_gt),
        .o_lt    (alu_lt)
    );

    psbd_slot_mem #(
        .DEPTH (TRACK_SLOTS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_slot),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_walk_idx),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_item.command == CMD_CLEAR) ? ST_CLR : ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_walk_idx == LAST_IDX) begin
                    n_state = ST_WALK_END;
                end
            end
            ST_WALK_END: n_state = ST_DECIDE;
            ST_DECIDE:   n_state = ST_WIN;
            ST_WIN:      n_state = ST_FIRE;
            ST_FIRE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLR: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state-driven outputs and shared unit operand select
    always_comb begin
        o_in_ready = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        alu_base   = mem_rdata.window_start;
        alu_limit  = r_best_age;
        o_res      = '0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_WALK: mem_re = 1'b1;
            ST_WIN: begin
                alu_base  = r_ws;
                alu_limit = {16'd0, i_cfg.window_ms};
            end
            ST_FIRE: begin
                alu_base                 = r_lf;
                alu_limit                = {12'd0, i_cfg.cooldown_ms};
                mem_we                   = i_out_free;
                o_res.vld                = i_out_free;
                o_res.item.burst_detected = fire;
                o_res.item.frame_count    = r_cnt;
            end
            ST_CLR: o_res.vld = i_out_free;
            default: ;
        endcase
    end

    // walk evaluation
    assign slot_is_valid = r_valid[r_eval_idx];
    assign hit = r_eval_vld && slot_is_valid && (mem_rdata.address == r_mac);

    assign slot_sel = r_found     ? r_match_idx :
                      r_have_free ? r_free_idx  : r_best_idx;

    // window restart, then saturating count
    assign cnt_base = alu_gt ? '0 : r_cnt;
    assign cnt_inc  = (cnt_base == CNT_MAX) ? CNT_MAX : cnt_base + CNT_W'(1);

    // last fire of zero means never fired
    assign fire = (r_cnt >= i_cfg.burst_frames) && !((r_lf != '0) && alu_lt);

    assign mem_wdata = '{address:      r_mac,
                         window_start: r_ws,
                         frame_count:  r_cnt,
                         last_fire:    fire ? r_now : r_lf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_eval_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_eval_vld <= (r_state == ST_WALK);
            if (r_state == ST_DECIDE) begin
                r_valid[slot_sel] <= 1'b1;
            end
            if (r_state == ST_CLR && i_out_free) begin
                r_valid <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_walk_idx;
        if (r_state == ST_IDLE && i_in_valid) begin
            r_mac       <= i_in_item.transmitter_mac;
            r_now       <= i_in_item.now_ms;
            r_walk_idx  <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_best_age  <= '0;
            r_best_idx  <= '0;
        end
        if (r_state == ST_WALK) begin
            r_walk_idx <= r_walk_idx + IW'(1);
        end
        if (r_eval_vld) begin
            if (hit && !r_found) begin
                r_found     <= 1'b1;
                r_match_idx <= r_eval_idx;
                r_ent       <= mem_rdata;
            end
            if (!slot_is_valid && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_eval_idx;
            end
            // oldest window wins; strict compare keeps the lowest slot on ties
            if (slot_is_valid && alu_gt) begin
                r_best_age <= alu_diff;
                r_best_idx <= r_eval_idx;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_slot <= slot_sel;
            if (r_found) begin
                r_ws  <= r_ent.window_start;
                r_cnt <= r_ent.frame_count;
                r_lf  <= r_ent.last_fire;
            end else begin
                r_ws  <= r_now;
                r_cnt <= '0;
                r_lf  <= '0;
            end
        end
        if (r_state == ST_WIN) begin
            if (alu_gt) begin
                r_ws <= r_now;
            end
            r_cnt <= cnt_inc;
        end
    end

endmodule

`default_nettype wire

FILE: design/per_source_burst_detector_unit.sv
// Per-source burst detector, top level. Depends on psbd_pkg and psbd_seq.
// Frame item: slot walk, then the WALK_END, DECIDE, WIN and FIRE steps; the result is
//   registered on leaving FIRE once the output is free, then IDLE takes the next item.
// Clear item: the CLR state registers the result once the output is free, then returns to IDLE.
// Reset (sync, active low): all trackers invalid, registers to defaults, output empty.
// Table contents are not swept at reset; entries are only used while valid.
`default_nettype none

module per_source_burst_detector_unit #(
    parameter int TRACK_SLOTS = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire psbd_pkg::t_in_item                 i_in_item,
    // result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output psbd_pkg::t_out_item                     o_out_item,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [psbd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [psbd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import psbd_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_vld;
    t_out_item r_out_item;
    logic      out_free;
    t_seq_res  seq_res;

    // Config registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms    <= WINDOW_RST;
            r_cfg.burst_frames <= BURST_RST;
            r_cfg.cooldown_ms  <= COOLDOWN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW:   r_cfg.window_ms    <= i_cfg_data[WIN_W-1:0];
                CFG_BURST:    r_cfg.burst_frames <= i_cfg_data[CNT_W-1:0];
                CFG_COOLDOWN: r_cfg.cooldown_ms  <= i_cfg_data[CD_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: frees when the downstream side takes the item, so the
    // sequencer can finish the next one in the same cycle.
    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (seq_res.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res.vld) begin
            r_out_item <= seq_res.item;
        end
    end

    // Slot walk, tracker update and table storage
    psbd_seq #(
        .TRACK_SLOTS (TRACK_SLOTS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_res      (seq_res)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: design/psbd_checker.sv
// Port-level checks for the burst detector, bound to the top level.
// Depends on psbd_pkg.
`default_nettype none

module psbd_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire psbd_pkg::t_in_item   i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire psbd_pkg::t_out_item  o_out_item
);
    import psbd_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // a result waits, unchanged, until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("item taken while previous one in flight");

    // only a clear yields count zero, and a clear never reports a burst
    a_zero_no_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.frame_count == '0) |-> !o_out_item.burst_detected)
        else $error("burst reported with zero count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind per_source_burst_detector_unit psbd_checker u_psbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

FILE: test/tb_per_source_burst_detector_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for per_source_burst_detector_unit (needs psbd_pkg and the RTL).
// Directed, random and long single-source items, checked against an in-bench tracker table.

module tb_per_source_burst_detector_unit;
    import psbd_pkg::*;

    localparam int SLOTS       = 4;
    localparam int DONE_CYCLES = SLOTS + 8;
    localparam int QUIET_LIMIT = 4000;       // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 300;        // long result back-pressure stretch
    localparam int RAND_ITEMS  = 330;
    localparam int POOL_SIZE   = 6;          // sources per phase, more than the table holds
    localparam int MAX_PRINTS  = 40;
    localparam int LONG_ITEMS  = 100;        // frames from one source in the long run

    typedef enum {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} t_pressure;

    // Tracker table mirror plus the queue of results still owed by the block.
    class burst_scoreboard;
        bit                slot_used  [SLOTS];
        bit [MAC_W-1:0]    slot_mac   [SLOTS];
        bit [TIME_W-1:0]   slot_start [SLOTS];
        bit [CNT_W-1:0]    slot_count [SLOTS];
        bit [TIME_W-1:0]   slot_fired [SLOTS];   // 0 = never reported
        bit [WIN_W-1:0]    window_ms;
        bit [CNT_W-1:0]    burst_frames;
        bit [CD_W-1:0]     cooldown_ms;
        t_out_item         owed_reports[$];
        int                mismatches;
        int                reports_checked;
        int                bursts_flagged;

        function new();
            clear_table();
            set_config(WINDOW_RST, BURST_RST, COOLDOWN_RST);
            mismatches      = 0;
            reports_checked = 0;
            bursts_flagged  = 0;
        endfunction

        function void clear_table();
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i]  = 1'b0;
                slot_mac[i]   = '0;
                slot_start[i] = '0;
                slot_count[i] = '0;
                slot_fired[i] = '0;
            end
        endfunction

        function void set_config(bit [WIN_W-1:0] w, bit [CNT_W-1:0] b, bit [CD_W-1:0] c);
            window_ms    = w;
            burst_frames = b;
            cooldown_ms  = c;
        endfunction

        // Matching valid slot, else lowest free one, else the oldest window (ties low).
        function int claim_slot(bit [MAC_W-1:0] mac, bit [TIME_W-1:0] now);
            int              pick;
            bit [TIME_W-1:0] age_i;
            bit [TIME_W-1:0] age_pick;
            pick = 0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_mac[i] == mac)
                    return i;
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_used[i]) begin
                    pick = i;
                    break;
                end
                age_i    = now - slot_start[i];
                age_pick = now - slot_start[pick];
                if (age_i > age_pick)
                    pick = i;
            end
            slot_used[pick]  = 1'b1;
            slot_mac[pick]   = mac;
            slot_start[pick] = now;
            slot_count[pick] = '0;
            slot_fired[pick] = '0;
            return pick;
        endfunction

        function void note_item(t_in_item it);
            t_out_item       want;
            int              s;
            bit [TIME_W-1:0] now;
            bit [TIME_W-1:0] elapsed;
            bit [TIME_W-1:0] since;
            want = '0;
            if (it.command == CMD_CLEAR) begin
                clear_table();
            end else begin
                now     = it.now_ms;
                s       = claim_slot(it.transmitter_mac, now);
                elapsed = now - slot_start[s];
                if (elapsed > window_ms) begin
                    slot_start[s] = now;
                    slot_count[s] = '0;
                end
                if (slot_count[s] != CNT_MAX)
                    slot_count[s] = slot_count[s] + 1'b1;
                if (slot_count[s] >= burst_frames) begin
                    since = now - slot_fired[s];
                    if (slot_fired[s] == 0 || since >= cooldown_ms) begin
                        slot_fired[s]       = now;
                        want.burst_detected = 1'b1;
                    end
                end
                want.frame_count = slot_count[s];
            end
            owed_reports.push_back(want);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("MISMATCH at result %0d (%0t): %s", reports_checked, $time, msg);
        endtask

        task check_report(t_out_item got);
            t_out_item want;
            reports_checked++;
            if (owed_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result burst=%0b count=%0d",
                                          got.burst_detected, got.frame_count));
                return;
            end
            want = owed_reports.pop_front();
            if (got.burst_detected !== want.burst_detected)
                report_mismatch($sformatf("burst_detected %0b, expected %0b",
                                          got.burst_detected, want.burst_detected));
            if (got.frame_count !== want.frame_count)
                report_mismatch($sformatf("frame_count %0d, expected %0d",
                                          got.frame_count, want.frame_count));
            if (want.burst_detected)
                bursts_flagged++;
        endtask

        function int pending();
            return owed_reports.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    burst_scoreboard       sb;
    bit                    tx_gaps   = 1'b0;  // sender idles between items
    bit                    rx_gaps   = 1'b0;  // receiver stalls between results
    bit                    hold_req  = 1'b0;  // ask the result side for a long stall
    int                    quiet_cycles = 0;
    int                    items_sent   = 0;
    int                    phase_no     = 0;
    logic [MAC_W-1:0]      mac_pool [POOL_SIZE];
    bit [TIME_W-1:0]       clock_ms;

    per_source_burst_detector_unit #(
        .TRACK_SLOTS (SLOTS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Any handshake resets the quiet counter; a hung block ends the run.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check each accepted result, then draw the stall before the next one.
    // A hold request turns into one long stall so the block backs up into its input.
    initial begin : result_sink
        int rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                sb.check_report(out_item);
                rx_wait = rx_gaps ? $urandom_range(0, 5) : 0;
            end
            if (hold_req) begin
                hold_req = 1'b0;
                rx_wait  = HOLD_CYCLES;
            end
            if (rx_wait > 0) begin
                out_ready <= 1'b0;
                rx_wait--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item make_item(logic cmd, logic [MAC_W-1:0] mac,
                                           logic [TIME_W-1:0] now);
        t_in_item it;
        it.command         = cmd;
        it.transmitter_mac = mac;
        it.now_ms          = now;
        return it;
    endfunction

    // Offer one item and return at the edge that takes it. Valid is left high so a
    // back-to-back item just swaps the payload.
    task automatic send_item(t_in_item it);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Drop valid, wait for every owed result, then let the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (DONE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges; only called while idle.
    task automatic load_settings(bit [WIN_W-1:0] w, bit [CNT_W-1:0] b, bit [CD_W-1:0] c);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW;
        cfg_data <= {{(CFG_DATA_W-WIN_W){1'b0}}, w};
        @(posedge clk);
        cfg_idx  <= CFG_BURST;
        cfg_data <= {{(CFG_DATA_W-CNT_W){1'b0}}, b};
        @(posedge clk);
        cfg_idx  <= CFG_COOLDOWN;
        cfg_data <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_config(w, b, c);
    endtask

    // Random phase: a small pool of sources (more than the table holds) and a clock
    // that mostly steps around the window and cooldown, with rare jumps and wraps.
    task automatic run_random(int count, t_pressure press);
        int              pick;
        int              r;
        bit [63:0]       wide;
        bit [TIME_W-1:0] span;
        t_in_item        it;
        phase_no++;
        tx_gaps = (phase_no % 2) == 0;
        rx_gaps = (phase_no % 3) != 1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            wide        = {$urandom, $urandom};
            mac_pool[i] = wide[MAC_W-1:0];
        end
        clock_ms = $urandom;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2 && press == PRESS_HOLD)
                hold_req = 1'b1;
            if (n == count / 2 && press == PRESS_PAUSE)
                wait_drained();
            span = sb.window_ms;
            r    = $urandom_range(0, 99);
            if (r < 45)
                clock_ms += $urandom_range(0, span / 3);
            else if (r < 60)
                clock_ms += span - 1 + $urandom_range(0, 2);    // right at the window edge
            else if (r < 73)
                clock_ms += $urandom_range(0, 2 * span + 2);
            else if (r < 82)
                clock_ms += $urandom_range(0, sb.cooldown_ms);
            else if (r < 88)
                clock_ms = $urandom;
            else if (r < 91)
                clock_ms = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF - $urandom_range(0, span);
            // otherwise same millisecond as the previous frame
            pick = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                              : $urandom_range(4, POOL_SIZE - 1);
            it = make_item(CMD_FRAME, mac_pool[pick], clock_ms);
            if ($urandom_range(0, 99) < 3) begin
                wide = {$urandom, $urandom};
                it   = make_item(CMD_CLEAR, wide[MAC_W-1:0], $urandom);
            end
            send_item(it);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        bit [63:0]        wide;
        logic [MAC_W-1:0] run_mac;
        bit [TIME_W-1:0]  run_base;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults first
        run_random(150, PRESS_NONE);

        // Directed: tiny window/threshold/cooldown so each corner is a few items away.
        load_settings(16'd10, 16'd2, 20'd20);
        send_item(make_item(CMD_FRAME, '0, 32'd0));                  // first free slot
        send_item(make_item(CMD_FRAME, '0, 32'd0));                  // fires at time zero
        send_item(make_item(CMD_FRAME, '0, 32'd1));                  // zero fire time: no cooldown
        send_item(make_item(CMD_FRAME, '0, 32'd2));                  // inside cooldown
        send_item(make_item(CMD_FRAME, '1, 32'd5));
        send_item(make_item(CMD_FRAME, 48'h8000_0000_0000, 32'd5));
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'd5));  // table now full
        send_item(make_item(CMD_FRAME, 48'h1234_5678_9ABC, 32'd6));  // evicts oldest window
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0002, 32'd6));  // equal ages: lowest slot
        send_item(make_item(CMD_FRAME, '1, 32'd7));                  // evicted source is new again
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'd16)); // gap past window restarts
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'd26)); // gap equal to window keeps
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'd36));
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'd46));
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'd46)); // same millisecond: inside cooldown
        send_item(make_item(CMD_CLEAR, '1, 32'hFFFF_FFFF));
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'hFFFF_FFFF));
        send_item(make_item(CMD_FRAME, 48'h0000_0000_0001, 32'd5));  // window across the wrap
        send_item(make_item(CMD_FRAME, 48'h5555_AAAA_5555, 32'hFFFF_FFFE));
        send_item(make_item(CMD_CLEAR, '0, 32'd0));
        wait_drained();

        load_settings(16'd1, 16'd1, 20'd0);
        run_random(RAND_ITEMS, PRESS_NONE);
        load_settings(16'hFFFF, 16'd3, 20'hF_FFFF);
        run_random(RAND_ITEMS, PRESS_HOLD);
        load_settings(16'd50, 16'd4, 20'd100);
        run_random(RAND_ITEMS, PRESS_PAUSE);
        load_settings(WIN_W'($urandom_range(1, 2000)), CNT_W'($urandom_range(1, 8)),
                      CD_W'($urandom_range(0, 5000)));
        run_random(RAND_ITEMS, PRESS_NONE);
        load_settings(16'd1, 16'd2, 20'd1);
        run_random(RAND_ITEMS, PRESS_NONE);

        // Long run: one source, high threshold, clock barely moving, so the count
        // climbs to the threshold, fires there, then keeps firing past a short cooldown.
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        load_settings(16'hFFFF, 16'd90, 20'd2);
        wide     = {$urandom, $urandom};
        run_mac  = wide[MAC_W-1:0];
        run_base = $urandom | 32'h1;
        for (int k = 0; k < LONG_ITEMS; k++)
            send_item(make_item(CMD_FRAME, run_mac, run_base + (k >> 4)));
        run_base += 8;
        repeat (12) begin
            run_base += $urandom_range(0, 2);
            send_item(make_item(CMD_FRAME, run_mac, run_base));
        end
        wait_drained();

        $display("Checked %0d results (%0d bursts) from %0d items over %0d random phases,",
                 sb.reports_checked, sb.bursts_flagged, items_sent, phase_no);
        $display("plus directed corners and a long single-source run; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
